/* rtl/cgc_pkg.sv */
`default_nettype none
package cgc_pkg;
    typedef enum logic [14:0] {
        S_LOAD     = 15'b000000000000001,
        S_CLEAR    = 15'b000000000000010,
        S_PICK_RD  = 15'b000000000000100,
        S_PICK     = 15'b000000000001000,
        S_MARK     = 15'b000000000010000,
        S_UPD_RD   = 15'b000000000100000,
        S_UPD      = 15'b000000001000000,
        S_ZSTART   = 15'b000000010000000,
        S_ZSETW    = 15'b000000100000000,
        S_ZSCAN_RD = 15'b000001000000000,
        S_ZSCAN    = 15'b000010000000000,
        S_ZWALK_RD = 15'b000100000000000,
        S_ZWALK    = 15'b001000000000000,
        S_ZNEXT    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;
endpackage
`default_nettype wire

/* rtl/chordal_graph_check_unit.sv */
// Rows are taken one item per cycle while the unit is loading and no result is waiting.
// A last row starts the check: a clearing pass, N search steps and the zero fill-in test,
// with every table read registered. No row is taken until the result has left.
// Reset (synchronous, active low) sets the vertex count to 64 and empties the output
// register; the adjacency rows are undefined until written.
`default_nettype none
module chordal_graph_check_unit
    import cgc_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,          // vertex_count [6:0]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,        // row_index [5:0], row_bits [69:6]
    input  wire logic        s_axis_tlast,        // last_row
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata         // chordal [0]
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = VW + 1;

    t_state r_state, n_state;
    logic [6:0]    r_vcount;
    logic [CW-1:0] r_n;
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    // The numbered flag sits above the neighbour count.
    logic [CW:0]   r_mcs [MAX_VERTICES];
    logic [VW-1:0] r_ordnum [MAX_VERTICES];
    logic [VW-1:0] r_vat [MAX_VERTICES];
    logic [VW-1:0] r_fol [MAX_VERTICES];
    logic [VW-1:0] r_high [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_adjq;
    logic [CW:0]   r_mcsq;
    logic [VW-1:0] r_ordq, r_vatq, r_folq, r_highq;
    logic [CW-1:0] r_num, r_v, r_i, r_guard;
    logic [VW-1:0] r_best, r_x;
    logic [CW-1:0] r_bestcnt;
    logic          r_bestok;
    logic          r_res, r_ovalid;

    logic [5:0]  w_row;
    logic [63:0] w_bits;
    logic [VW-1:0] w_vi, w_ii, w_numi;
    logic [CW-1:0] w_nclip;
    logic          w_vlast, w_hit, w_step;

    assign w_row   = s_axis_tdata[5:0];
    assign w_bits  = s_axis_tdata[69:6];
    assign w_vi    = r_v[VW-1:0];
    assign w_ii    = r_i[VW-1:0];
    assign w_numi  = VW'(r_num - CW'(1));
    assign w_vlast = (r_v == r_n - CW'(1));
    assign w_hit   = r_adjq[w_vi] && (r_ordq < w_ii);
    assign w_step  = (r_highq < w_ii) && (r_guard < CW'(MAX_VERTICES));

    always_comb begin
        if (r_vcount == 7'd0) begin
            w_nclip = CW'(1);
        end else if (r_vcount > 7'(MAX_VERTICES)) begin
            w_nclip = CW'(MAX_VERTICES);
        end else begin
            w_nclip = CW'(r_vcount);
        end
    end

    assign s_axis_tready = (r_state == S_LOAD) && !r_ovalid;
    assign o_cfg_ready   = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_res};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:     if (s_axis_tvalid && s_axis_tready && s_axis_tlast) n_state = S_CLEAR;
            S_CLEAR:    if (w_vlast) n_state = S_PICK_RD;
            S_PICK_RD:  n_state = S_PICK;
            S_PICK:     n_state = w_vlast ? S_MARK : S_PICK_RD;
            S_MARK:     n_state = S_UPD_RD;
            S_UPD_RD:   n_state = S_UPD;
            S_UPD:      if (w_vlast) begin
                n_state = (r_num == CW'(1)) ? S_ZSTART : S_PICK_RD;
            end else begin
                n_state = S_UPD_RD;
            end
            S_ZSTART:   n_state = S_ZSETW;
            S_ZSETW:    n_state = S_ZSCAN_RD;
            S_ZSCAN_RD: n_state = S_ZSCAN;
            S_ZSCAN:    if (w_hit) begin
                n_state = S_ZWALK_RD;
            end else if (w_vlast) begin
                n_state = S_ZNEXT;
            end else begin
                n_state = S_ZSCAN_RD;
            end
            S_ZWALK_RD: n_state = S_ZWALK;
            S_ZWALK:    if (w_step) begin
                n_state = r_adjq[r_x] ? S_ZWALK_RD : S_DONE;
            end else begin
                n_state = w_vlast ? S_ZNEXT : S_ZSCAN_RD;
            end
            S_ZNEXT:    n_state = (r_i == r_n - CW'(1)) ? S_DONE : S_ZSTART;
            S_DONE:     n_state = S_LOAD;
            default:    n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_vcount <= 7'd64;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_cfg_data[6:0];
            if (r_state == S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_adjq  <= r_adj[r_best];
        r_mcsq  <= r_mcs[w_vi];
        r_ordq  <= r_ordnum[w_vi];
        r_vatq  <= r_vat[w_ii];
        r_folq  <= r_fol[r_x];
        r_highq <= r_high[r_x];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid && s_axis_tready && int'(w_row) < MAX_VERTICES) begin
                    r_adj[w_row[VW-1:0]] <= w_bits[MAX_VERTICES-1:0];
                end
                r_n   <= w_nclip;
                r_num <= w_nclip;
                r_v   <= '0;
            end
            S_CLEAR: begin
                r_mcs[w_vi] <= '0;
                r_res       <= 1'b1;
                r_bestok    <= 1'b0;
                r_v         <= w_vlast ? '0 : r_v + CW'(1);
            end
            S_PICK_RD: ;
            S_PICK: begin
                if (!r_mcsq[CW] && (!r_bestok || r_mcsq[CW-1:0] > r_bestcnt)) begin
                    r_bestok  <= 1'b1;
                    r_bestcnt <= r_mcsq[CW-1:0];
                    r_best    <= w_vi;
                end
                r_v <= w_vlast ? '0 : r_v + CW'(1);
            end
            S_MARK: begin
                r_mcs[r_best]    <= {1'b1, r_bestcnt};
                r_ordnum[r_best] <= w_numi;
                r_vat[w_numi]    <= r_best;
            end
            S_UPD_RD: ;
            S_UPD: begin
                if (r_adjq[w_vi] && !r_mcsq[CW]) begin
                    r_mcs[w_vi] <= {1'b0, r_mcsq[CW-1:0] + CW'(1)};
                end
                if (w_vlast) begin
                    r_v      <= '0;
                    r_num    <= r_num - CW'(1);
                    r_bestok <= 1'b0;
                    r_i      <= '0;
                end else begin
                    r_v <= r_v + CW'(1);
                end
            end
            S_ZSTART: ;
            S_ZSETW: begin
                r_best         <= r_vatq;
                r_fol[r_vatq]  <= r_vatq;
                r_high[r_vatq] <= w_ii;
                r_v            <= '0;
            end
            S_ZSCAN_RD: ;
            S_ZSCAN: begin
                r_x     <= w_vi;
                r_guard <= '0;
                if (!w_hit && !w_vlast) r_v <= r_v + CW'(1);
            end
            S_ZWALK_RD: ;
            S_ZWALK: begin
                if (w_step) begin
                    r_high[r_x] <= w_ii;
                    if (!r_adjq[r_x]) r_res <= 1'b0;
                    r_x     <= r_folq;
                    r_guard <= r_guard + CW'(1);
                end else begin
                    if (r_folq == r_x) r_fol[r_x] <= r_best;
                    if (!w_vlast) r_v <= r_v + CW'(1);
                end
            end
            S_ZNEXT: r_i <= r_i + CW'(1);
            S_DONE: ;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* tb/chordal_check_monitor.sv */
`default_nettype none
module chordal_check_monitor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,          // vertex_count [6:0]
    input  wire logic        i_row_valid,
    input  wire logic        i_row_ready,
    input  wire logic [71:0] i_row_data,          // row_index [5:0], row_bits [69:6]
    input  wire logic        i_row_last,          // last_row
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire logic [7:0]  i_res_data,          // chordal [0]
    output int               o_errors,
    output int               o_pending
);
    logic [63:0] rows [64];
    logic [6:0]  count_reg;
    bit          chordal_q [$];

    // Orders the vertices by maximum cardinality search, then runs the zero
    // fill-in test with follower and index tables.
    function automatic bit chordal_of(int n);
        int  tally [64];
        bit  done [64];
        int  num_of [64];
        int  vert_at [64];
        int  fol [64];
        int  seen [64];
        int  best, best_cnt, x, w, guard;
        for (int v = 0; v < 64; v++) begin
            tally[v] = 0;
            done[v] = 0;
        end
        for (int k = n; k > 0; k--) begin
            best = 0;
            best_cnt = -1;
            for (int v = 0; v < n; v++) begin
                if (!done[v] && tally[v] > best_cnt) begin
                    best_cnt = tally[v];
                    best = v;
                end
            end
            done[best] = 1;
            num_of[best] = k - 1;
            vert_at[k - 1] = best;
            for (int u = 0; u < n; u++) begin
                if (rows[best][u] && !done[u]) tally[u] = (tally[u] + 1) & 127;
            end
        end
        for (int i = 0; i < n; i++) begin
            w = vert_at[i];
            fol[w] = w;
            seen[w] = i;
            for (int v = 0; v < n; v++) begin
                if (rows[w][v] && num_of[v] < i) begin
                    x = v;
                    guard = 0;
                    while (seen[x] < i && guard < 64) begin
                        seen[x] = i;
                        if (!rows[w][x]) return 0;
                        x = fol[x];
                        guard++;
                    end
                    if (fol[x] == x) fol[x] = w;
                end
            end
        end
        return 1;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        int n;
        bit want;
        if (!i_rst_n) begin
            count_reg = 7'd64;
        end else begin
            if (i_cfg_valid && i_cfg_ready) count_reg = i_cfg_data[6:0];
            if (i_row_valid && i_row_ready) begin
                rows[i_row_data[5:0]] = i_row_data[69:6];
                if (i_row_last) begin
                    n = count_reg;
                    if (n > 64) n = 64;
                    if (n == 0) n = 1;
                    chordal_q.push_back(chordal_of(n));
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (chordal_q.size() == 0) begin
                    report("unexpected result", i_res_data[0], -1);
                end else begin
                    want = chordal_q.pop_front();
                    if (i_res_data[0] !== want) report("chordal flag", i_res_data[0], want);
                end
            end
            o_pending = chordal_q.size();
        end
    end
endmodule
`default_nettype wire

/* tb/tb_chordal_graph_check_unit.sv */
`default_nettype none
module tb_chordal_graph_check_unit;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_valid = 0;
    logic [7:0]  cfg_data = 0;
    logic        row_valid = 0;
    logic [71:0] row_data = 0;
    logic        row_last = 0;
    logic        res_ready = 0;
    wire logic   cfg_ready, row_ready, res_valid;
    wire logic [7:0] res_data;
    int          errors, pending;

    logic [63:0] graph [64];
    int          n_cur = 64;
    int          items_sent = 0;
    bit          calm = 0;
    bit          hold_req = 0;

    always #10 i_clk = ~i_clk;

    chordal_graph_check_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .s_axis_tvalid(row_valid), .s_axis_tready(row_ready),
        .s_axis_tdata(row_data), .s_axis_tlast(row_last),
        .m_axis_tvalid(res_valid), .m_axis_tready(res_ready), .m_axis_tdata(res_data)
    );

    chordal_check_monitor chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_row_valid(row_valid), .i_row_ready(row_ready),
        .i_row_data(row_data), .i_row_last(row_last),
        .i_res_valid(res_valid), .i_res_ready(res_ready), .i_res_data(res_data),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int draw_gap();
        if (calm) return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [63:0] used_mask(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    task automatic send_row(input int idx, input logic [63:0] bits, input bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            row_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        row_data <= {2'b00, bits, idx[5:0]};
        row_last <= last;
        row_valid <= 1;
        @(posedge i_clk);
        while (!row_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        row_valid <= 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(input int value);
        wait_idle();
        cfg_data <= {1'($urandom), value[6:0]};
        cfg_valid <= 1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 0;
        n_cur = (value == 0) ? 1 : ((value > 64) ? 64 : value);
    endtask

    function automatic void add_edge(int a, int b);
        graph[a][b] = 1;
        graph[b][a] = 1;
    endfunction

    // Shapes: random density, chordal by construction, a chordless cycle,
    // complete, empty.
    task automatic build_graph(input int n, input int shape);
        int perm [64];
        int t, p, u, v, density;
        logic [63:0] members;
        for (int k = 0; k < 64; k++) begin
            graph[k] = '0;
            perm[k] = k;
        end
        for (int k = n - 1; k > 0; k--) begin
            t = $urandom_range(0, k);
            p = perm[k];
            perm[k] = perm[t];
            perm[t] = p;
        end
        case (shape)
            0: begin
                density = $urandom_range(1, 15);
                for (int a = 0; a < n; a++)
                    for (int b = a + 1; b < n; b++)
                        if ($urandom_range(0, 15) < density) add_edge(a, b);
            end
            1: begin
                for (int i = 1; i < n; i++) begin
                    v = perm[i];
                    if ($urandom_range(0, 7) == 0) continue;
                    p = perm[$urandom_range(0, i - 1)];
                    add_edge(v, p);
                    members = '0;
                    members[p] = 1;
                    for (int j = 0; j < i; j++) begin
                        u = perm[j];
                        if (u != p && (graph[u] & members) == members && $urandom_range(0, 2) != 0)
                        begin
                            add_edge(v, u);
                            members[u] = 1;
                        end
                    end
                end
            end
            2: begin
                t = $urandom_range((n < 4) ? n : 4, n);
                for (int i = 0; i < t; i++) add_edge(perm[i], perm[(i + 1) % t]);
            end
            3: begin
                for (int a = 0; a < n; a++)
                    for (int b = a + 1; b < n; b++) add_edge(a, b);
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) graph[$urandom_range(0, n - 1)][$urandom_range(0, n - 1)] ^= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, n - 1);
            graph[v][v] = 1;
        end
        if ($urandom_range(0, 1) == 0)
            for (int a = 0; a < n; a++)
                graph[a] |= {$urandom, $urandom} & ~used_mask(n);
    endtask

    // Sends every used row in random order; the last of them, or a spare row
    // beyond the vertex count, carries the last flag.
    task automatic send_graph(input int n);
        int order [64];
        int t, p;
        bit spare_last;
        for (int k = 0; k < n; k++) order[k] = k;
        for (int k = n - 1; k > 0; k--) begin
            t = $urandom_range(0, k);
            p = order[k];
            order[k] = order[t];
            order[t] = p;
        end
        spare_last = (n < 64) && ($urandom_range(0, 5) == 0);
        for (int k = 0; k < n; k++) begin
            if (n < 64 && $urandom_range(0, 9) == 0)
                send_row($urandom_range(n, 63), {$urandom, $urandom}, 0);
            send_row(order[k], graph[order[k]], (k == n - 1) && !spare_last);
        end
        if (spare_last) send_row($urandom_range(n, 63), {$urandom, $urandom}, 1);
    endtask

    initial begin
        int value, graphs, phase, v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        write_count(0);
        send_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        write_count(1);
        send_row(0, 64'h0, 1);
        write_count(2);
        send_row(1, 64'h1, 0);
        send_row(0, 64'h2, 1);
        write_count(4);
        build_graph(4, 2);
        send_graph(4);
        write_count(5);
        build_graph(5, 1);
        send_graph(5);
        send_row(2, graph[2] ^ 64'h1, 1);

        phase = 0;
        while (items_sent < 1950) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 19))
                0: value = 64;
                1: value = 127;
                2: value = 1;
                3: value = 0;
                default: value = $urandom_range(2, 10);
            endcase
            write_count(value);
            if (phase == 3) hold_req = 1;
            graphs = (n_cur > 16) ? 1 : 5;
            for (int g = 0; g < graphs; g++) begin
                build_graph(n_cur, $urandom_range(0, 5));
                send_graph(n_cur);
                if ($urandom_range(0, 3) == 0) begin
                    v = $urandom_range(0, n_cur - 1);
                    send_row(v, graph[v] ^ (64'd1 << $urandom_range(0, n_cur - 1)), 1);
                end
            end
            phase++;
        end
        row_valid <= 0;
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_chordal_graph_check_unit OK");
        end else begin
            $display("tb_chordal_graph_check_unit NOT OK");
        end
        $finish;
    end

    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (hold_req) begin
                hold_req = 0;
                gap = 2000;
            end
            if (gap > 0) begin
                res_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            res_ready <= 1;
            @(posedge i_clk);
            while (!res_valid) @(posedge i_clk);
        end
    end

    initial begin
        #200000000;
        $display("tb_chordal_graph_check_unit NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
